/* hdl/arp_cache_responder_assert.svh */
// Assertion macros used by the cache module of the ARP cache and responder.
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ACR_ASSERT_IMP(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ACR_ASSERT_NXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* hdl/acr_pkg.sv */
// Types and constants shared by the ARP cache and responder modules.
package acr_pkg;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int LEN_W = 11;
   localparam int OPC_W = 16;

   localparam logic [LEN_W-1:0] ARP_MIN_LEN    = 11'd28;
   localparam logic [OPC_W-1:0] ARP_OP_REQUEST = 16'd1;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 48;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUR_IP  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUR_MAC = 1'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_REPLY = 2'd1,
      KIND_HIT   = 2'd2,
      KIND_MISS  = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_LEARN,
      CMD_LOOKUP
   } cmd_op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SELECT,
      BACK_READ
   } back_state_type;

   typedef struct packed {
      cmd_op_type       op;
      logic             reply;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } cmd_type;

   typedef struct packed {
      result_kind_type  kind;
      logic [MAC_W-1:0] reply_dest_mac;
      logic [IP_W-1:0]  reply_dest_ip;
      logic [MAC_W-1:0] found_mac;
   } rsp_type;

endpackage

/* hdl/acr_queue.sv */
// Two-entry first-in first-out queue used between the stages of the responder.
module acr_queue
   import acr_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == QUEUE_DEPTH[QUEUE_PTR_W:0]);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/acr_front.sv */
// Front end: configuration register, item intake and classification into commands.
module acr_front
   import acr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_op,
   input  logic [LEN_W-1:0]       req_packet_length,
   input  logic [OPC_W-1:0]       req_arp_opcode,
   input  logic [MAC_W-1:0]       req_sender_mac,
   input  logic [IP_W-1:0]        req_src_ip,
   input  logic [IP_W-1:0]        req_tgt_ip,
   input  logic [IP_W-1:0]        req_lookup_ip,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   cmd_full,
   output logic                   cmd_push,
   output cmd_type                cmd_data
);

   logic [IP_W-1:0] our_ip_ff, our_ip_in;

   assign csr_ready = 1'b1;
   assign full      = cmd_full;
   assign cmd_push  = push && !cmd_full;

   // The host MAC is only the sender field of the outgoing frame, which is built
   // elsewhere, so a write to that register changes nothing here.
   always_comb begin
      our_ip_in = our_ip_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OUR_IP:  our_ip_in = csr_data[IP_W-1:0];
            CSR_OUR_MAC: our_ip_in = our_ip_ff;
            default:     our_ip_in = our_ip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         our_ip_ff <= '0;
      end else begin
         our_ip_ff <= our_ip_in;
      end
   end

   always_comb begin
      cmd_data       = '0;
      cmd_data.op    = CMD_PASS;
      cmd_data.reply = 1'b0;
      if (req_op == OP_LOOKUP) begin
         cmd_data.op = CMD_LOOKUP;
         cmd_data.ip = req_lookup_ip;
      end else if (req_packet_length >= ARP_MIN_LEN) begin
         cmd_data.reply = (req_arp_opcode == ARP_OP_REQUEST) && (req_tgt_ip == our_ip_ff);
         cmd_data.op    = (req_src_ip != '0) ? CMD_LEARN : CMD_PASS;
         cmd_data.ip    = req_src_ip;
         cmd_data.mac   = req_sender_mac;
      end
   end

endmodule

/* hdl/acr_cache.sv */
// Back end: address cache with parallel compare, slot selection and MAC store.
`include "arp_cache_responder_assert.svh"

module acr_cache
   import acr_pkg::*;
#(
   parameter int CACHE_ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_in,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   back_state_type           state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [CACHE_ENTRIES-1:0] cmp_ff, cmp_in;
   logic [CACHE_ENTRIES-1:0] entry_valid_ff;
   logic [IP_W-1:0]          entry_ip_ff [CACHE_ENTRIES];
   logic [MAC_W-1:0]         entry_mac [CACHE_ENTRIES];
   logic [MAC_W-1:0]         mac_rd_ff;
   logic [CACHE_ENTRIES-1:0] first_vec;
   logic [IDX_W-1:0]         sel_idx;
   logic                     any_set;
   logic                     load;
   logic                     wr_en;
   logic                     rd_en;

   function automatic rsp_type packet_result(input cmd_type cmd);
      rsp_type res;
      res      = '0;
      res.kind = KIND_NONE;
      if (cmd.reply) begin
         res.kind           = KIND_REPLY;
         res.reply_dest_mac = cmd.mac;
         res.reply_dest_ip  = cmd.ip;
      end
      return res;
   endfunction

   // A lookup marks valid entries holding the key; a learn marks entries that are
   // free or already hold the key. Either way the lowest marked entry wins.
   always_comb begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (cmd_in.op == CMD_LOOKUP) begin
            cmp_in[i] = entry_valid_ff[i] && (entry_ip_ff[i] == cmd_in.ip);
         end else begin
            cmp_in[i] = !entry_valid_ff[i] || (entry_ip_ff[i] == cmd_in.ip);
         end
      end
   end

   assign first_vec = cmp_ff & (~cmp_ff + CACHE_ENTRIES'(1));
   assign any_set   = |cmp_ff;

   // With no entry marked the index is zero, which is the overwrite slot of a full cache.
   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (first_vec[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      load     = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               load    = 1'b1;
               if (cmd_in.op == CMD_PASS) begin
                  rsp_push = 1'b1;
                  rsp_data = packet_result(cmd_in);
               end else begin
                  state_in = BACK_SELECT;
               end
            end
         end
         BACK_SELECT: begin
            case (cmd_ff.op)
               CMD_LEARN: begin
                  wr_en    = 1'b1;
                  rsp_push = 1'b1;
                  rsp_data = packet_result(cmd_ff);
                  state_in = BACK_IDLE;
               end
               CMD_LOOKUP: begin
                  if (any_set) begin
                     rd_en    = 1'b1;
                     state_in = BACK_READ;
                  end else begin
                     rsp_push      = 1'b1;
                     rsp_data.kind = KIND_MISS;
                     state_in      = BACK_IDLE;
                  end
               end
               default: begin
                  state_in = BACK_IDLE;
               end
            endcase
         end
         BACK_READ: begin
            rsp_push           = 1'b1;
            rsp_data.kind      = KIND_HIT;
            rsp_data.found_mac = mac_rd_ff;
            state_in           = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
         cmp_ff <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[sel_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ip_ff[sel_idx] <= cmd_ff.ip;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mac[sel_idx] <= cmd_ff.mac;
      end
      if (rd_en) begin
         mac_rd_ff <= entry_mac[sel_idx];
      end
   end

   `ACR_ASSERT_IMP(a_pop_when_idle, cmd_pop, (state_ff == BACK_IDLE) && !rsp_full, "command taken outside idle or with result queue full")
   `ACR_ASSERT_IMP(a_read_delivers, state_ff == BACK_READ, rsp_push, "lookup hit did not deliver its item")
   `ACR_ASSERT_NXT(a_learn_marks, (state_ff == BACK_SELECT) && (cmd_ff.op == CMD_LEARN), (state_ff == BACK_IDLE) && (entry_valid_ff != '0), "learned entry not marked valid")
   `ACR_ASSERT_IMP(a_valid_grows, !$past(reset), $countones(entry_valid_ff) >= $past($countones(entry_valid_ff)), "valid entries lost outside reset")

endmodule

/* hdl/arp_cache_responder.sv */
// Top level of the ARP cache and responder: front end, command queue, cache and result queue.
//
// This block keeps a cache of IPv4-to-Ethernet bindings learned from received ARP
// packets and answers lookups against it. An item is either a parsed ARP packet
// (op 0) or a lookup (op 1); every item yields exactly one result item. Packets
// shorter than 28 bytes give result kind "nothing". Other packets teach the cache
// their nonzero sender IP (first free or matching slot, slot 0 when full) and give
// a reply descriptor when they are requests for our_ip. Lookups return the MAC of
// the lowest valid matching slot, or a miss. The front end classifies an item in
// the cycle it is accepted and drops a command into a two-entry queue, so it can
// take a new item every cycle until that queue fills. The back end works on one
// command at a time: a command that needs no cache work finishes where it is taken,
// a learn or a lookup miss after the parallel compare and a slot select with the
// write or the miss result, and a lookup hit after the compare, a select with the
// MAC store read and a deliver step. A new command waits until the last is done,
// so the compare/select sequence and the MAC store's single read port set the rate.
// Results wait in a two-entry queue; the back end starts a command only when that
// queue has room. Valid bits clear in the reset cycle itself, so there is no
// start-up sweep. The configuration port is always ready; our_ip should be written
// only while no item is in flight.
module arp_cache_responder
   import acr_pkg::*;
#(
   parameter int CACHE_ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_op,
   input  logic [LEN_W-1:0]       req_packet_length,
   input  logic [OPC_W-1:0]       req_arp_opcode,
   input  logic [MAC_W-1:0]       req_sender_mac,
   input  logic [IP_W-1:0]        req_src_ip,
   input  logic [IP_W-1:0]        req_tgt_ip,
   input  logic [IP_W-1:0]        req_lookup_ip,
   output logic                   empty,
   input  logic                   pop,
   output logic [1:0]             rsp_result_kind,
   output logic [MAC_W-1:0]       rsp_reply_dest_mac,
   output logic [IP_W-1:0]        rsp_reply_dest_ip,
   output logic [MAC_W-1:0]       rsp_found_mac,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // Command path between the front end and the cache.
   cmd_type          cmd_wr;
   logic             cmd_push;
   logic             cmd_full;
   logic [CMD_W-1:0] cmd_rd_vec;
   cmd_type          cmd_rd;
   logic             cmd_pop;
   logic             cmd_empty;

   // Result path between the cache and the output queue.
   rsp_type          rsp_wr;
   logic             rsp_push;
   logic             rsp_q_full;
   logic [RSP_W-1:0] rsp_rd_vec;
   rsp_type          rsp_rd;

   acr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_op            (req_op),
      .req_packet_length (req_packet_length),
      .req_arp_opcode    (req_arp_opcode),
      .req_sender_mac    (req_sender_mac),
      .req_src_ip        (req_src_ip),
      .req_tgt_ip        (req_tgt_ip),
      .req_lookup_ip     (req_lookup_ip),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd_full          (cmd_full),
      .cmd_push          (cmd_push),
      .cmd_data          (cmd_wr)
   );

   acr_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_vec),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   assign cmd_rd = cmd_type'(cmd_rd_vec);

   acr_cache #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_cache (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_in    (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   acr_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .pop       (pop),
      .pop_data  (rsp_rd_vec),
      .full      (rsp_q_full),
      .empty     (empty)
   );

   // The oldest waiting result item is shown on the result ports.
   assign rsp_rd             = rsp_type'(rsp_rd_vec);
   assign rsp_result_kind    = rsp_rd.kind;
   assign rsp_reply_dest_mac = rsp_rd.reply_dest_mac;
   assign rsp_reply_dest_ip  = rsp_rd.reply_dest_ip;
   assign rsp_found_mac      = rsp_rd.found_mac;

endmodule

/* tb/tb_arp_cache_responder.sv */
// Self-checking testbench for the ARP cache and responder, with its own cache predictor.
`timescale 1ns / 1ps

module tb_arp_cache_responder;
   import acr_pkg::*;

   localparam int CACHE_ENTRIES = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 6;
   localparam int POOL_SIZE     = 24;
   localparam int PRINT_LIMIT   = 200;
   localparam logic [OPC_W-1:0] ARP_OP_REPLY = 16'd2;

   // One input item, field for field as the request ports carry it.
   typedef struct packed {
      logic             op;
      logic [LEN_W-1:0] packet_length;
      logic [OPC_W-1:0] arp_opcode;
      logic [MAC_W-1:0] sender_mac;
      logic [IP_W-1:0]  src_ip;
      logic [IP_W-1:0]  tgt_ip;
      logic [IP_W-1:0]  lookup_ip;
   } arp_item_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic                   req_op;
   logic [LEN_W-1:0]       req_packet_length;
   logic [OPC_W-1:0]       req_arp_opcode;
   logic [MAC_W-1:0]       req_sender_mac;
   logic [IP_W-1:0]        req_src_ip;
   logic [IP_W-1:0]        req_tgt_ip;
   logic [IP_W-1:0]        req_lookup_ip;
   logic                   empty;
   logic                   pop;
   logic [1:0]             rsp_result_kind;
   logic [MAC_W-1:0]       rsp_reply_dest_mac;
   logic [IP_W-1:0]        rsp_reply_dest_ip;
   logic [MAC_W-1:0]       rsp_found_mac;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Shadow copy of the host registers and of the cache contents.
   logic [IP_W-1:0]  host_ip;
   logic [MAC_W-1:0] host_mac;
   logic [IP_W-1:0]  cache_ip    [CACHE_ENTRIES];
   logic [MAC_W-1:0] cache_mac   [CACHE_ENTRIES];
   logic             cache_valid [CACHE_ENTRIES];

   // Results predicted for accepted items, oldest first.
   rsp_type pending_results[$];

   // Addresses that recur in the random traffic so that lookups hit and
   // learned entries get refreshed instead of always being new.
   logic [IP_W-1:0] ip_pool [POOL_SIZE];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   int  rsp_hold_cycles = 0;

   arp_cache_responder #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_packet_length  (req_packet_length),
      .req_arp_opcode     (req_arp_opcode),
      .req_sender_mac     (req_sender_mac),
      .req_src_ip         (req_src_ip),
      .req_tgt_ip         (req_tgt_ip),
      .req_lookup_ip      (req_lookup_ip),
      .empty              (empty),
      .pop                (pop),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_reply_dest_mac (rsp_reply_dest_mac),
      .rsp_reply_dest_ip  (rsp_reply_dest_ip),
      .rsp_found_mac      (rsp_found_mac),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The watchdog ends a run that hangs, for example when a result never comes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Predict the result of one item and update the shadow cache the way the
   // block does. A lookup scans for the lowest valid matching slot. A packet
   // of legal length learns its nonzero sender into the first slot that is
   // free or already holds that address, falling back to slot 0 when the
   // cache is full, and then answers a request aimed at our address.
   function automatic rsp_type resolve_arp_item(arp_item_type it);
      rsp_type r = '0;
      int      slot = 0;
      bit      found = 1'b0;
      r.kind = KIND_NONE;
      if (it.op == OP_LOOKUP) begin
         r.kind = KIND_MISS;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (!found && cache_valid[i] && cache_ip[i] == it.lookup_ip) begin
               found = 1'b1;
               r.kind = KIND_HIT;
               r.found_mac = cache_mac[i];
            end
         end
      end else if (it.packet_length >= ARP_MIN_LEN) begin
         if (it.src_ip != '0) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (!found && (!cache_valid[i] || cache_ip[i] == it.src_ip)) begin
                  found = 1'b1;
                  slot = i;
               end
            end
            cache_ip[slot] = it.src_ip;
            cache_mac[slot] = it.sender_mac;
            cache_valid[slot] = 1'b1;
         end
         if (it.arp_opcode == ARP_OP_REQUEST && it.tgt_ip == host_ip) begin
            r.kind = KIND_REPLY;
            r.reply_dest_mac = it.sender_mac;
            r.reply_dest_ip = it.src_ip;
         end
      end
      return r;
   endfunction

   function automatic arp_item_type packet_item(logic [LEN_W-1:0] len,
                                                logic [OPC_W-1:0] opcode,
                                                logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                                logic [IP_W-1:0] tip);
      arp_item_type it;
      it.op = OP_PACKET;
      it.packet_length = len;
      it.arp_opcode = opcode;
      it.sender_mac = smac;
      it.src_ip = sip;
      it.tgt_ip = tip;
      it.lookup_ip = $urandom;
      return it;
   endfunction

   // The packet fields of a lookup are noise that the block must ignore.
   function automatic arp_item_type lookup_item(logic [IP_W-1:0] ip);
      arp_item_type it;
      it = packet_item(11'($urandom), 16'($urandom), {16'($urandom), $urandom},
                       $urandom, $urandom);
      it.op = OP_LOOKUP;
      it.lookup_ip = ip;
      return it;
   endfunction

   function automatic logic [IP_W-1:0] pick_ip();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 9) begin
         return $urandom;
      end
      return '0;
   endfunction

   // Packets and lookups at random; packets are mostly well-formed requests and
   // replies, with short packets, odd opcodes and zero senders mixed in.
   function automatic arp_item_type make_random_item();
      arp_item_type it;
      int        pick;
      logic [LEN_W-1:0] len;
      logic [OPC_W-1:0] opcode;
      logic [IP_W-1:0]  tip;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         len = 11'($urandom_range(ARP_MIN_LEN, 2047));
      end else if (pick < 9) begin
         len = 11'($urandom_range(0, ARP_MIN_LEN - 1));
      end else begin
         len = 11'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         opcode = ARP_OP_REQUEST;
      end else if (pick < 8) begin
         opcode = ARP_OP_REPLY;
      end else begin
         opcode = 16'($urandom);
      end
      tip = ($urandom_range(0, 1) == 0) ? host_ip : pick_ip();
      it = packet_item(len, opcode, {16'($urandom), $urandom}, pick_ip(), tip);
      it.lookup_ip = pick_ip();
      it.op = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      end
   endtask

   // Compare the result on the ports with the oldest prediction.
   task automatic check_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing pending, kind", 64'(rsp_result_kind), 64'd0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_result_kind != want.kind) begin
            report_mismatch("result_kind", 64'(rsp_result_kind), 64'(want.kind));
         end
         if (rsp_reply_dest_mac != want.reply_dest_mac) begin
            report_mismatch("reply_dest_mac", 64'(rsp_reply_dest_mac),
                            64'(want.reply_dest_mac));
         end
         if (rsp_reply_dest_ip != want.reply_dest_ip) begin
            report_mismatch("reply_dest_ip", 64'(rsp_reply_dest_ip), 64'(want.reply_dest_ip));
         end
         if (rsp_found_mac != want.found_mac) begin
            report_mismatch("found_mac", 64'(rsp_found_mac), 64'(want.found_mac));
         end
      end
   endtask

   // A result item moves at a rising edge with pop high and empty low.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         check_result();
      end
   end

   // The receiver: pop changes on the falling edge. A long hold requested by
   // a test takes priority, then any short stall burst already running, and
   // otherwise a new burst starts now and then while idling is enabled.
   initial begin : rsp_pacer
      int stall_left;
      stall_left = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            pop = 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            pop = 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            pop = 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            pop = 1'b1;
         end
      end
   end

   // Offer one item from a falling edge and hold it until the block takes it.
   // The prediction is made at the accepting edge, so the shadow cache sees
   // items in the same order as the block. Push stays high on return so that
   // back-to-back items need no gap; req_gap and wait_idle lower it.
   task automatic send_item(input arp_item_type it);
      req_op = it.op;
      req_packet_length = it.packet_length;
      req_arp_opcode = it.arp_opcode;
      req_sender_mac = it.sender_mac;
      req_src_ip = it.src_ip;
      req_tgt_ip = it.tgt_ip;
      req_lookup_ip = it.lookup_ip;
      push = 1'b1;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      pending_results.push_back(resolve_arp_item(it));
      @(negedge clock);
   endtask

   task automatic req_gap(input int cycles);
      push = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stop offering items and wait until every predicted result has arrived,
   // then let the back end settle.
   task automatic wait_idle();
      push = 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Registers are only written while nothing is in flight.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (index == CSR_OUR_IP) begin
         host_ip = data[IP_W-1:0];
      end else begin
         host_mac = data;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // The unused upper bits of the address write carry random noise.
   task automatic set_host(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
      write_csr(CSR_OUR_IP, {16'($urandom), ip});
      write_csr(CSR_OUR_MAC, mac);
   endtask

   // An empty cache misses everything, and a short packet neither learns
   // nor replies even when it is a request for our address.
   task automatic test_empty_cache();
      send_item(lookup_item('0));
      send_item(lookup_item('1));
      send_item(packet_item(LEN_W'(ARP_MIN_LEN - 1), ARP_OP_REQUEST, 48'h0200_0000_0A0A,
                            32'h0A0A_0A0A, host_ip));
      send_item(lookup_item(32'h0A0A_0A0A));
      wait_idle();
   endtask

   // Replies only for requests to our address, learning from every legal
   // packet, a zero sender that still gets a reply, and a refresh of a known
   // address with a new MAC.
   task automatic test_learn_and_reply();
      send_item(packet_item(ARP_MIN_LEN, ARP_OP_REQUEST, '1, 32'hC0A8_0001, host_ip));
      send_item(lookup_item(32'hC0A8_0001));
      send_item(packet_item(11'd100, ARP_OP_REPLY, 48'h0200_0000_0002, 32'hC0A8_0002,
                            host_ip));
      send_item(packet_item(11'd2047, '1, '0, '1, host_ip));
      send_item(packet_item(11'd60, ARP_OP_REQUEST, 48'hA5A5_5A5A_F00D, '0, host_ip));
      send_item(packet_item(11'd2047, ARP_OP_REQUEST, 48'h0200_0000_00AA, 32'hC0A8_0001,
                            ~host_ip));
      send_item(lookup_item(32'hC0A8_0001));
      send_item(lookup_item(32'hC0A8_0002));
      send_item(lookup_item('1));
      wait_idle();
   endtask

   // Three addresses are already cached; thirteen more fill every slot and
   // one further address must replace slot 0, which holds the first one.
   task automatic test_full_cache();
      for (int i = 0; i < CACHE_ENTRIES - 3; i++) begin
         send_item(packet_item(11'd64, OPC_W'(i % 3), {16'($urandom), $urandom},
                               32'h0A00_0100 + i, $urandom));
      end
      send_item(packet_item(11'd64, ARP_OP_REQUEST, 48'h0200_0000_01FF, 32'h0A00_01FF,
                            host_ip));
      send_item(lookup_item(32'hC0A8_0001));
      send_item(lookup_item(32'h0A00_01FF));
      wait_idle();
   endtask

   // The receiver stops for a long stretch while items keep coming, so the
   // queues fill and full must hold the sender off without losing anything.
   task automatic test_receiver_holdoff();
      rsp_hold_cycles = 150;
      repeat (16) send_item(make_random_item());
      wait_idle();
   endtask

   // Short bursts, each followed by a pause until every result is back.
   task automatic test_drain_pause();
      repeat (3) begin
         repeat (5) send_item(make_random_item());
         wait_idle();
      end
   endtask

   // One phase of random traffic under one host setting.
   task automatic test_random_traffic(input int items, input logic [IP_W-1:0] ip,
                                      input logic [MAC_W-1:0] mac);
      set_host(ip, mac);
      repeat (items) begin
         send_item(make_random_item());
         if (req_idle_on && $urandom_range(0, 7) == 0) begin
            req_gap($urandom_range(1, 12));
         end
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_op = OP_PACKET;
      req_packet_length = '0;
      req_arp_opcode = '0;
      req_sender_mac = '0;
      req_src_ip = '0;
      req_tgt_ip = '0;
      req_lookup_ip = '0;
      csr_valid = 1'b0;
      csr_index = CSR_OUR_IP;
      csr_data = '0;
      host_ip = '0;
      host_mac = '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         cache_ip[i] = '0;
         cache_mac[i] = '0;
         cache_valid[i] = 1'b0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         do begin
            ip_pool[i] = $urandom;
         end while (ip_pool[i] == '0);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_host(32'hC0A8_00FE, 48'h0200_5E00_00FE);
      test_empty_cache();
      test_learn_and_reply();
      test_full_cache();
      test_receiver_holdoff();
      test_drain_pause();

      // Random phases start with the extreme host settings; the last one
      // runs with no idling on either side.
      test_random_traffic(225, '0, '1);
      test_random_traffic(225, '1, '0);
      test_random_traffic(225, ip_pool[$urandom_range(0, POOL_SIZE - 1)],
                          {16'($urandom), $urandom});
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_traffic(225, $urandom, {16'($urandom), $urandom});

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
